[hw/rtl/sphf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package sphf_pkg;
  localparam int DataWidth = 32;
  localparam int FracBits = 16;
  localparam int AccWidth = 48;
  localparam int CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] RegScale = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegRadius = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegRadiusSq = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegSpiky = 2'd3;

  typedef logic signed [DataWidth-1:0] sdata_t;
  typedef logic [DataWidth-1:0] udata_t;
  typedef logic signed [AccWidth-1:0] acc_t;

  localparam sdata_t SMax = sdata_t'({1'b0, {(DataWidth-1){1'b1}}});
  localparam sdata_t SMin = sdata_t'({1'b1, {(DataWidth-1){1'b0}}});

  // Classified pair handed from front to back.
  typedef struct packed {
    logic   active;
    logic   last;
    sdata_t dx;
    sdata_t dy;
    sdata_t dz;
    sdata_t vx;
    sdata_t vy;
    sdata_t vz;
    sdata_t psum;
    udata_t invo;
    udata_t invn;
    udata_t visc;
    udata_t d2;
  } pair_t;

  // Fixed-point product: exact, shift toward zero, saturate. Sets sat on clamp.
  function automatic sdata_t qmul(input logic signed [DataWidth:0] a,
                                  input logic signed [DataWidth:0] b,
                                  output logic sat);
    logic [DataWidth:0] ma;
    logic [DataWidth:0] mb;
    logic [2*DataWidth+1:0] p;
    logic [2*DataWidth+1:0] s;
    logic neg;
    ma = a[DataWidth] ? (DataWidth+1)'(-a) : a;
    mb = b[DataWidth] ? (DataWidth+1)'(-b) : b;
    neg = a[DataWidth] ^ b[DataWidth];
    p = ma * mb;
    s = p >> FracBits;
    sat = 1'b0;
    if (neg) begin
      if (s > (2*DataWidth+2)'(SMax) + 1) begin
        sat = 1'b1;
        qmul = SMin;
      end else begin
        qmul = sdata_t'(-s);
      end
    end else begin
      if (s > (2*DataWidth+2)'(SMax)) begin
        sat = 1'b1;
        qmul = SMax;
      end else begin
        qmul = sdata_t'(s);
      end
    end
  endfunction

  function automatic sdata_t clampd(input logic signed [DataWidth+1:0] v,
                                    output logic sat);
    sat = 1'b0;
    if (v > (DataWidth+2)'(SMax)) begin
      sat = 1'b1;
      clampd = SMax;
    end else if (v < (DataWidth+2)'(SMin)) begin
      sat = 1'b1;
      clampd = SMin;
    end else begin
      clampd = sdata_t'(v);
    end
  endfunction
endpackage
`default_nettype wire

[hw/rtl/sphf_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module sphf_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire sphf_pkg::sdata_t dxi,
  input  wire sphf_pkg::sdata_t dyi,
  input  wire sphf_pkg::sdata_t dzi,
  input  wire sphf_pkg::sdata_t vxi,
  input  wire sphf_pkg::sdata_t vyi,
  input  wire sphf_pkg::sdata_t vzi,
  input  wire sphf_pkg::sdata_t po,
  input  wire sphf_pkg::sdata_t pn,
  input  wire sphf_pkg::udata_t io,
  input  wire sphf_pkg::udata_t inn,
  input  wire sphf_pkg::udata_t vis,
  input  wire logic           lst,
  input  wire sphf_pkg::udata_t scale,
  input  wire sphf_pkg::udata_t rsq,
  output logic                q_valid,
  output sphf_pkg::pair_t     q_data,
  input  wire logic           q_pop
);
  import sphf_pkg::*;
  // Stage 1: scale; stage 2: square/sum/classify; then a two-entry queue.
  logic s1_v, s2_v;
  pair_t s1, s2;
  pair_t s2_in, f_in;
  logic s1_far, s2_far;
  pair_t fifo [2];
  logic [1:0] cnt;
  logic rd;
  logic wr_ptr;
  logic adv2, adv1;
  logic f0, f1, f2, g0, g1, g2;
  sdata_t ex, ey, ez, qx, qy, qz;
  logic signed [DataWidth+1:0] sum2;
  logic ig;
  sdata_t psum_c;

  assign adv2 = s2_v && (cnt != 2'd2 || q_pop);
  assign adv1 = s1_v && (!s2_v || adv2);
  assign in_stall = s1_v && !adv1;

  always_comb begin
    ex = qmul((DataWidth+1)'(dxi), (DataWidth+1)'({1'b0, scale}), f0);
    ey = qmul((DataWidth+1)'(dyi), (DataWidth+1)'({1'b0, scale}), f1);
    ez = qmul((DataWidth+1)'(dzi), (DataWidth+1)'({1'b0, scale}), f2);
    psum_c = clampd((DataWidth+2)'(po) + (DataWidth+2)'(pn), ig);
    qx = qmul((DataWidth+1)'(s1.dx), (DataWidth+1)'(s1.dx), g0);
    qy = qmul((DataWidth+1)'(s1.dy), (DataWidth+1)'(s1.dy), g1);
    qz = qmul((DataWidth+1)'(s1.dz), (DataWidth+1)'(s1.dz), g2);
    sum2 = (DataWidth+2)'($unsigned(qx)) + (DataWidth+2)'($unsigned(qy))
         + (DataWidth+2)'($unsigned(qz));
    s2_in = s1;
    s2_in.d2 = (sum2 > (DataWidth+2)'({DataWidth{1'b1}})) ? '1 : udata_t'(sum2);
    f_in = s2;
    f_in.active = !s2_far && s2.d2 != '0 && s2.d2 < rsq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      cnt <= 2'd0;
      rd <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_v <= 1'b1;
        s1 <= '{active: 1'b0, last: lst, dx: ex, dy: ey, dz: ez, vx: vxi, vy: vyi,
                vz: vzi, psum: psum_c, invo: io, invn: inn, visc: vis, d2: '0};
        s1_far <= f0 | f1 | f2;
      end else if (adv1) begin
        s1_v <= 1'b0;
      end
      if (adv1) begin
        s2_v <= 1'b1;
        s2 <= s2_in;
        s2_far <= s1_far | g0 | g1 | g2;
      end else if (adv2) begin
        s2_v <= 1'b0;
      end
      if (adv2) begin
        fifo[wr_ptr] <= f_in;
        wr_ptr <= !wr_ptr;
      end
      if (q_pop && cnt != 2'd0) rd <= !rd;
      cnt <= cnt + 2'(adv2) - 2'(q_pop && cnt != 2'd0);
    end
  end
  assign q_valid = cnt != 2'd0;
  assign q_data = fifo[rd];
endmodule
`default_nettype wire

[hw/rtl/sphf_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module sphf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire sphf_pkg::pair_t q_data,
  output logic                q_pop,
  input  wire sphf_pkg::udata_t radius,
  input  wire sphf_pkg::udata_t spiky,
  output logic                out_valid,
  input  wire logic           out_stall,
  output sphf_pkg::sdata_t    fx,
  output sphf_pkg::sdata_t    fy,
  output sphf_pkg::sdata_t    fz,
  output logic                oflag
);
  import sphf_pkg::*;
  localparam logic [3:0] StIdle = 4'd0, StSqrt = 4'd1, StC = 4'd2, StT1 = 4'd3,
    StT2 = 4'd4, StDiv = 4'd5, StD1 = 4'd6, StD2 = 4'd7, StAx = 4'd8, StFx = 4'd9,
    StAcc = 4'd10, StEmit = 4'd11;
  localparam int RootW = (DataWidth + FracBits + 1) / 2;
  localparam int SqSteps = RootW;
  localparam int DivSteps = DataWidth + FracBits;
  localparam int QW = DataWidth + FracBits;
  localparam int DnW = 2 * DataWidth + FracBits;

  logic [3:0] state;
  pair_t p;
  logic [6:0] step;
  logic [2*RootW-1:0] sq_src;
  logic [RootW+1:0] sq_rem;
  logic [RootW-1:0] root;
  sdata_t c, pterm, dterm, m1;
  logic [DataWidth:0] dn_rem;
  logic [QW-1:0] quo;
  logic [DnW-1:0] dn_num;
  logic dn_neg;
  logic [1:0] axis;
  sdata_t ax;
  sdata_t fv [3];
  acc_t acc [3];
  logic sat_seen;
  logic sa, sb, sc2;
  sdata_t pa, pb, mres, ares, pd;
  logic signed [DataWidth+1:0] csum;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] rem_sh;
  logic [DataWidth:0] dsh;
  logic [QW-1:0] qlim;
  logic [AccWidth:0] asum;
  sdata_t e [3];
  logic ef [3];
  logic signed [DataWidth:0] mul_a, mul_b;

  assign q_pop = (state == StIdle) && q_valid;
  assign qlim = QW'({1'b0, SMax}) + QW'(1);

  always_comb begin
    rem_sh = {sq_rem[RootW-1:0], sq_src[2*RootW-1 -: 2]};
    trial = {root, 2'b01};
    dsh = {dn_rem[DataWidth-1:0], dn_num[DnW-1]};
    mul_a = '0;
    mul_b = '0;
    case (state)
      StT1: begin mul_a = (DataWidth+1)'(c); mul_b = (DataWidth+1)'({1'b0, spiky}); end
      StT2: begin mul_a = (DataWidth+1)'(m1); mul_b = (DataWidth+1)'(p.psum); end
      StD1: begin mul_a = (DataWidth+1)'(c); mul_b = (DataWidth+1)'({1'b0, p.invo}); end
      StD2: begin mul_a = (DataWidth+1)'(m1); mul_b = (DataWidth+1)'({1'b0, p.invn}); end
      StFx: begin mul_a = (DataWidth+1)'(ax); mul_b = (DataWidth+1)'(dterm); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mres = qmul(mul_a, mul_b, sa);
    case (axis)
      2'd0: begin
        pa = qmul((DataWidth+1)'(pterm), (DataWidth+1)'(p.dx), sb);
        pb = qmul((DataWidth+1)'({1'b0, p.visc}), (DataWidth+1)'(p.vx), sc2);
      end
      2'd1: begin
        pa = qmul((DataWidth+1)'(pterm), (DataWidth+1)'(p.dy), sb);
        pb = qmul((DataWidth+1)'({1'b0, p.visc}), (DataWidth+1)'(p.vy), sc2);
      end
      default: begin
        pa = qmul((DataWidth+1)'(pterm), (DataWidth+1)'(p.dz), sb);
        pb = qmul((DataWidth+1)'({1'b0, p.visc}), (DataWidth+1)'(p.vz), sc2);
      end
    endcase
    ares = clampd((DataWidth+2)'(pa) + (DataWidth+2)'(pb), sc2);
    csum = (DataWidth+2)'({1'b0, radius}) - (DataWidth+2)'({1'b0, root});
    pd = clampd(csum, sb);
    for (int i = 0; i < 3; i++) begin
      ef[i] = 1'b0;
      e[i] = clampd((DataWidth+2)'(acc[i]) , ef[i]);
      if (acc[i] > AccWidth'(SMax)) begin
        e[i] = SMax;
        ef[i] = 1'b1;
      end else if (acc[i] < AccWidth'(SMin)) begin
        e[i] = SMin;
        ef[i] = 1'b1;
      end
    end
    asum = (AccWidth+1)'(acc[axis]) + (AccWidth+1)'(fv[axis]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
      out_valid <= 1'b0;
      sat_seen <= 1'b0;
      for (int i = 0; i < 3; i++) acc[i] <= '0;
    end else begin
      if (out_valid && !out_stall && state != StEmit) out_valid <= 1'b0;
      case (state)
        StIdle: if (q_valid) begin
          p <= q_data;
          sq_src <= (2*RootW)'({q_data.d2, {FracBits{1'b0}}});
          sq_rem <= '0;
          root <= '0;
          step <= '0;
          state <= q_data.active ? StSqrt : (q_data.last ? StEmit : StIdle);
        end
        StSqrt: begin
          if (rem_sh >= trial) begin
            sq_rem <= rem_sh - trial;
            root <= {root[RootW-2:0], 1'b1};
          end else begin
            sq_rem <= rem_sh;
            root <= {root[RootW-2:0], 1'b0};
          end
          sq_src <= sq_src << 2;
          step <= step + 7'd1;
          if (step == 7'(SqSteps - 1)) state <= StC;
        end
        StC: begin c <= pd; state <= StT1; end
        StT1: begin m1 <= mres; state <= StT2; end
        StT2: begin
          dn_neg <= mres[DataWidth-1];
          dn_num <= DnW'({(mres[DataWidth-1] ? udata_t'(-mres) : udata_t'(mres)),
                          {FracBits{1'b0}}}) << (DnW - DataWidth - FracBits);
          dn_rem <= '0;
          quo <= '0;
          step <= '0;
          state <= (root == '0) ? StD1 : StDiv;
          if (root == '0) pterm <= '0;
        end
        StDiv: begin
          dn_num <= dn_num << 1;
          step <= step + 7'd1;
          if (dsh >= (DataWidth+1)'(root)) begin
            dn_rem <= dsh - (DataWidth+1)'(root);
            quo <= {quo[QW-2:0], 1'b1};
          end else begin
            dn_rem <= dsh;
            quo <= {quo[QW-2:0], 1'b0};
          end
          if (step == 7'(DivSteps - 1)) state <= StD1;
        end
        StD1: begin
          if (root != '0 && p.active) begin
            if (dn_neg) pterm <= (quo >= qlim) ? sdata_t'(qlim >> 1)
              : sdata_t'((QW'(quo) >> 1));
            else pterm <= (quo > QW'(SMax)) ? -(SMax >>> 1) : -sdata_t'(quo >> 1);
          end
          m1 <= mres;
          state <= StD2;
        end
        StD2: begin dterm <= mres; axis <= 2'd0; state <= StAx; end
        StAx: begin ax <= ares; state <= StFx; end
        StFx: begin
          fv[axis] <= mres;
          if (axis == 2'd2) begin axis <= 2'd0; state <= StAcc; end
          else begin axis <= axis + 2'd1; state <= StAx; end
        end
        StAcc: begin
          if (asum[AccWidth] != asum[AccWidth-1]) begin
            acc[axis] <= asum[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}}
                                        : {1'b0, {(AccWidth-1){1'b1}}};
            sat_seen <= 1'b1;
          end else begin
            acc[axis] <= asum[AccWidth-1:0];
          end
          if (axis == 2'd2) state <= p.last ? StEmit : StIdle;
          else axis <= axis + 2'd1;
        end
        StEmit: if (!out_valid || !out_stall) begin
          out_valid <= 1'b1;
          fx <= e[0];
          fy <= e[1];
          fz <= e[2];
          oflag <= sat_seen | ef[0] | ef[1] | ef[2];
          for (int i = 0; i < 3; i++) acc[i] <= '0;
          sat_seen <= 1'b0;
          state <= StIdle;
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/sph_pair_force_accumulator.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Handshake              | Payload
// in       | in_valid / in_stall    | delta_*, vel_diff_*, pressures, inv densities, visc, last
// out      | out_valid / out_stall  | force_x/y/z, overflow_flag
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
// A pair in radius holds the back end while it is popped, through the square root,
// the radius difference, the multiply steps, the restoring divider, a combine and a
// multiply per axis for the force and an accumulate per axis; a last pair adds an emit step.
// A dropped pair is popped and skipped. The front scales and squares in two stages
// and queues two classified pairs; rst is synchronous and clears control and sums.
// A stalled result holds; the front keeps accepting until its queue and stages fill.
module sph_pair_force_accumulator (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic signed [31:0] delta_x,
  input  wire logic signed [31:0] delta_y,
  input  wire logic signed [31:0] delta_z,
  input  wire logic signed [31:0] vel_diff_x,
  input  wire logic signed [31:0] vel_diff_y,
  input  wire logic signed [31:0] vel_diff_z,
  input  wire logic signed [31:0] pressure_own,
  input  wire logic signed [31:0] pressure_other,
  input  wire logic [31:0] inv_density_own,
  input  wire logic [31:0] inv_density_other,
  input  wire logic [31:0] viscosity_term,
  input  wire logic last_pair,
  output logic      out_valid,
  input  wire logic out_stall,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic      overflow_flag,
  input  wire logic cfg_valid,
  output logic      cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import sphf_pkg::*;
  udata_t scale, radius, rsq, spiky;
  logic q_valid, q_pop;
  pair_t q_data;

  assign cfg_ready = 1'b1;
  // Hold each register until a transfer on its index.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale <= udata_t'(1) << FracBits;
      radius <= udata_t'(1) << FracBits;
      rsq <= udata_t'(1) << FracBits;
      spiky <= udata_t'(1) << FracBits;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegScale: scale <= cfg_data;
        RegRadius: radius <= cfg_data;
        RegRadiusSq: rsq <= cfg_data;
        RegSpiky: spiky <= cfg_data;
        default: scale <= scale;
      endcase
    end
  end

  sphf_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .dxi(delta_x), .dyi(delta_y), .dzi(delta_z),
    .vxi(vel_diff_x), .vyi(vel_diff_y), .vzi(vel_diff_z),
    .po(pressure_own), .pn(pressure_other),
    .io(inv_density_own), .inn(inv_density_other), .vis(viscosity_term),
    .lst(last_pair), .scale, .rsq, .q_valid, .q_data, .q_pop
  );

  sphf_back u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .radius, .spiky,
    .out_valid, .out_stall, .fx(force_x), .fy(force_y), .fz(force_z),
    .oflag(overflow_flag)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(force_x))
    else $error("result dropped while stalled");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
  import sphf_pkg::*;

  // One neighbour pair as it crosses the input channel.
  typedef struct {
    sdata_t dx, dy, dz;
    sdata_t vx, vy, vz;
    sdata_t p_own, p_other;
    udata_t invd_own, invd_other;
    udata_t visc;
    logic   last;
  } pair_item_t;

  // One emitted particle force.
  typedef struct {
    sdata_t fx, fy, fz;
    logic   ovf;
  } force_item_t;

  // Fixed-point force model plus the queue of forces still owed by the block.
  class force_board;
    force_item_t owed[$];
    longint      acc_x, acc_y, acc_z;
    bit          sat_seen;
    longint      scale, radius, radius_sq, spiky;
    int          mismatches;

    function void clear();
      scale = 65536; radius = 65536; radius_sq = 65536; spiky = 65536;
      acc_x = 0; acc_y = 0; acc_z = 0;
      sat_seen = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxWidth-1:0] idx, udata_t val);
      case (idx)
        RegScale:    scale = longint'(val);
        RegRadius:   radius = longint'(val);
        RegRadiusSq: radius_sq = longint'(val);
        RegSpiky:    spiky = longint'(val);
        default: ;
      endcase
    endfunction

    // Clamp a magnitude with sign to signed 32 bits.
    function longint to_signed(logic [63:0] m, bit neg, ref bit sat);
      logic [63:0] lim;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (m > lim) begin
        sat = 1;
        m = lim;
      end
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint clamp32(longint v, ref bit sat);
      if (v > 64'sh7FFF_FFFF) begin
        sat = 1;
        return 64'sh7FFF_FFFF;
      end
      if (v < -64'sh8000_0000) begin
        sat = 1;
        return -64'sh8000_0000;
      end
      return v;
    endfunction

    function longint fx_mul(longint a, longint b, ref bit sat);
      logic [63:0]  ma, mb;
      logic [127:0] p;
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      p = (128'(ma) * 128'(mb)) >> FracBits;
      if (p[127:64] != 0) begin
        sat = 1;
        p = '1;
      end
      return to_signed(p[63:0], (a < 0) != (b < 0), sat);
    endfunction

    function longint fx_div(longint n, longint d, ref bit sat);
      logic [63:0] mn;
      if (d == 0) return 0;
      mn = n < 0 ? -n : n;
      return to_signed((mn << FracBits) / d, n < 0, sat);
    endfunction

    // floor(sqrt(d2 * 2^FracBits))
    function longint fx_sqrt(longint d2);
      logic [63:0] v, res, b;
      v = 64'(d2) << FracBits;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return longint'(res);
    endfunction

    function void acc_add(ref longint acc, longint v);
      longint amax;
      amax = (64'sd1 <<< (AccWidth - 1)) - 1;
      if (v > 0 && acc > amax - v) begin
        acc = amax;
        sat_seen = 1;
      end else if (v < 0 && acc < -amax - 1 - v) begin
        acc = -amax - 1;
        sat_seen = 1;
      end else begin
        acc = acc + v;
      end
    endfunction

    // Fold one accepted pair into the model; queue a force on the last pair.
    function void note_pair(pair_item_t it);
      longint d[3], dv[3], f[3];
      longint d2, psum, r, c, t, pterm, dterm, a;
      bit far, ig, flag;
      force_item_t res;
      far = 0; ig = 0; d2 = 0;
      d[0] = fx_mul(longint'(it.dx), scale, far);
      d[1] = fx_mul(longint'(it.dy), scale, far);
      d[2] = fx_mul(longint'(it.dz), scale, far);
      dv[0] = longint'(it.vx); dv[1] = longint'(it.vy); dv[2] = longint'(it.vz);
      for (int i = 0; i < 3; i++) begin
        d2 = d2 + fx_mul(d[i], d[i], far);
        if (d2 > 64'sh FFFF_FFFF) d2 = 64'shFFFF_FFFF;
      end
      // Drop zero-distance, out-of-radius and overflowed-distance pairs.
      if (!far && d2 != 0 && d2 < radius_sq) begin
        psum = clamp32(longint'(it.p_own) + longint'(it.p_other), ig);
        r = fx_sqrt(d2);
        c = clamp32(radius - r, ig);
        t = fx_mul(fx_mul(c, spiky, ig), psum, ig);
        pterm = -(fx_div(t, r, ig) / 2);
        dterm = fx_mul(fx_mul(c, longint'(it.invd_own), ig), longint'(it.invd_other), ig);
        for (int i = 0; i < 3; i++) begin
          a = clamp32(fx_mul(pterm, d[i], ig) + fx_mul(longint'(it.visc), dv[i], ig), ig);
          f[i] = fx_mul(a, dterm, ig);
        end
        acc_add(acc_x, f[0]);
        acc_add(acc_y, f[1]);
        acc_add(acc_z, f[2]);
      end
      if (it.last) begin
        flag = sat_seen;
        res.fx = sdata_t'(clamp32(acc_x, flag));
        res.fy = sdata_t'(clamp32(acc_y, flag));
        res.fz = sdata_t'(clamp32(acc_z, flag));
        res.ovf = flag;
        owed.insert(owed.size(), res);
        acc_x = 0; acc_y = 0; acc_z = 0;
        sat_seen = 0;
      end
    endfunction

    function void check_force(force_item_t got);
      force_item_t exp_f;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected force %0d %0d %0d ovf %0b", got.fx, got.fy, got.fz, got.ovf);
        return;
      end
      exp_f = owed.pop_front();
      if (got.fx !== exp_f.fx || got.fy !== exp_f.fy || got.fz !== exp_f.fz ||
          got.ovf !== exp_f.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display("force exp %0d %0d %0d ovf %0b got %0d %0d %0d ovf %0b",
                   exp_f.fx, exp_f.fy, exp_f.fz, exp_f.ovf,
                   got.fx, got.fy, got.fz, got.ovf);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  sdata_t delta_x = 0, delta_y = 0, delta_z = 0;
  sdata_t vel_diff_x = 0, vel_diff_y = 0, vel_diff_z = 0;
  sdata_t pressure_own = 0, pressure_other = 0;
  udata_t inv_density_own = 0, inv_density_other = 0, viscosity_term = 0;
  logic last_pair = 0;
  logic out_valid;
  logic out_stall = 0;
  sdata_t force_x, force_y, force_z;
  logic overflow_flag;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CfgIdxWidth-1:0] cfg_index = RegScale;
  udata_t cfg_data = 0;

  force_board board = new();
  bit  quiet;        // when set, neither side inserts idle cycles
  int  delta_span;   // magnitude of well-formed position differences

  always #6 clk = ~clk;

  sph_pair_force_accumulator i_dut (.*);

  // Check every force transfer against the oldest owed force.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_force('{fx: force_x, fy: force_y, fz: force_z, ovf: overflow_flag});
  end

  // Stall the force channel for a random count of cycles per transfer.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Abort a hung run.
  initial begin
    #20_000_000;
    $display("sph_pair_force_accumulator: mismatch");
    $finish;
  end

  // Drive one pair and hold it until the block takes the transfer.
  task automatic send_pair(pair_item_t it);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    delta_x <= it.dx; delta_y <= it.dy; delta_z <= it.dz;
    vel_diff_x <= it.vx; vel_diff_y <= it.vy; vel_diff_z <= it.vz;
    pressure_own <= it.p_own; pressure_other <= it.p_other;
    inv_density_own <= it.invd_own; inv_density_other <= it.invd_other;
    viscosity_term <= it.visc;
    last_pair <= it.last;
    do @(posedge clk); while (in_stall);
    board.note_pair(it);
  endtask

  // Hold off until every owed force has come, then let the back end settle.
  task automatic drain();
    in_valid <= 0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // Present one register write; the caller drops cfg_valid after the last one.
  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, udata_t val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  task automatic write_all(udata_t s, udata_t h, udata_t h2, udata_t k);
    write_reg(RegScale, s);
    write_reg(RegRadius, h);
    write_reg(RegRadiusSq, h2);
    write_reg(RegSpiky, k);
    cfg_valid <= 0;
  endtask

  function automatic sdata_t small_signed(int unsigned m);
    sdata_t v;
    v = sdata_t'($urandom_range(0, m));
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // Pair with random content; noise pairs use the full field range.
  function automatic pair_item_t make_pair(bit noise, bit last);
    pair_item_t it;
    if (noise) begin
      it = '{sdata_t'($urandom), sdata_t'($urandom), sdata_t'($urandom),
             sdata_t'($urandom), sdata_t'($urandom), sdata_t'($urandom),
             sdata_t'($urandom), sdata_t'($urandom),
             $urandom, $urandom, $urandom, last};
      // Keep some noise pairs near the origin so full-range payloads land in radius.
      if ($urandom_range(0, 1)) begin
        it.dx = small_signed(delta_span);
        it.dy = small_signed(delta_span);
        it.dz = small_signed(delta_span);
      end
    end else begin
      it = '{small_signed(delta_span), small_signed(delta_span), small_signed(delta_span),
             small_signed(1 << 20), small_signed(1 << 20), small_signed(1 << 20),
             small_signed(1 << 22), small_signed(1 << 22),
             $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18),
             $urandom_range(0, 1 << 20), last};
    end
    return it;
  endfunction

  // Random particles of one to six pairs; roughly one pair in five is noise.
  task automatic random_particles(int pairs);
    int len;
    while (pairs > 0) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_pair(make_pair($urandom_range(0, 4) == 0, i == len - 1));
      pairs -= len;
      // Pause the sender mid-run, while 151 to 156 pairs remain, until the block has caught up.
      if (pairs > 150 && pairs <= 156) drain();
    end
  endtask

  initial begin
    pair_item_t it;
    board.clear();
    quiet = 0;
    delta_span = 40000;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed pairs at reset settings.
    it = '{0, 0, 0, 1000, 1000, 1000, 5000, 5000, 65536, 65536, 65536, 1};
    send_pair(it);                                       // zero distance
    it.dx = 70000; send_pair(it);                        // out of radius
    it.dx = SMax; it.dy = SMin; send_pair(it);           // distance overflow
    it = '{20000, -15000, 10000, SMax, SMin, SMax, SMax, SMax,
           '1, '1, '1, 0};
    send_pair(it);                                       // extreme payload
    it.p_own = SMin; it.p_other = SMin; send_pair(it);
    it.vx = SMin; it.last = 1; send_pair(it);           // output clamp
    it = '{-1, 1, -1, 0, 0, 0, -1, 1, 0, 0, 0, 1};
    send_pair(it);                                       // tiny distance
    for (int i = 0; i < 4; i++) send_pair(make_pair(0, i == 3));
    random_particles(350);
    drain();

    // Coarser scale, tighter radius; no idling for this stretch.
    quiet = 1;
    delta_span = 12000;
    write_all(32'h0002_0000, 32'h0000_8000, 32'h0000_4000, 32'h0003_0000);
    random_particles(350);
    drain();
    quiet = 0;

    // Radius far below the cut-off: negative kernel term.
    delta_span = 40000;
    write_all(32'h0001_0000, 32'h0000_1000, 32'h0001_0000, 32'h0000_8000);
    random_particles(300);
    drain();

    // All-ones registers.
    delta_span = 2;
    write_all('1, '1, '1, '1);
    for (int i = 0; i < 4; i++) send_pair(make_pair(0, i == 3));
    random_particles(250);
    drain();

    // All-zero registers: every pair drops.
    write_all('0, '0, '0, '0);
    random_particles(100);
    drain();

    // Random register settings.
    for (int ph = 0; ph < 3; ph++) begin
      delta_span = $urandom_range(100, 60000);
      write_all($urandom_range(32'h4000, 32'h2_0000), $urandom,
                $urandom_range(32'h1000, 32'h4_0000), $urandom);
      random_particles(150);
      drain();
    end

    if (board.mismatches == 0 && board.owed.size() == 0) begin
      $display("sph_pair_force_accumulator: match");
    end else begin
      $display("sph_pair_force_accumulator: mismatch");
    end
    $finish;
  end
endmodule

[files.f]
hw/rtl/sphf_pkg.sv
hw/rtl/sphf_front.sv
hw/rtl/sphf_back.sv
hw/rtl/sph_pair_force_accumulator.sv
verif/tb.sv
